>>> src/ara_pkg.sv
// ----------------------------------------------------------------------------
// ara_pkg: shared types and constants of the converter request arbiter
// holds command and status codes, sequencer states and control bundles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ara_pkg;

  // fixed field widths
  localparam int PortBits    = 4;
  localparam int ChanBits    = 4;
  localparam int OwnerBits   = 8;
  localparam int FlagBits    = 8;
  localparam int SampleW     = 12;
  localparam int RefBits     = 16;

  localparam int DefNumPorts = 12;
  localparam int MaxChannel  = 15;
  localparam int SampleBits  = 12;
  localparam logic [SampleW-1:0] SampleMask = SampleW'((64'd1 << SampleBits) - 64'd1);

  localparam logic [RefBits-1:0]  ResetReference = 16'h017d;
  localparam logic [ChanBits-1:0] ResetBandgap   = 4'd10;

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // stream payload widths
  localparam int InDataW  = 40;
  localparam int InUserW  = 2;
  localparam int OutDataW = 48;
  localparam int OutUserW = 2;

  typedef logic [PortBits-1:0]  port_t;
  typedef logic [ChanBits-1:0]  chan_t;
  typedef logic [OwnerBits-1:0] owner_t;
  typedef logic [FlagBits-1:0]  flags_t;

  typedef enum logic [1:0] {
    CMD_BIND    = 2'd0,
    CMD_UNBIND  = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_DONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_BUSY    = 2'd2,
    STS_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_SCAN = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

  // sequencer -> datapath
  typedef struct packed {
    logic ready;
    logic exec_en;
    logic scan_en;
    logic out_valid;
  } seq_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_fire;
    logic out_fire;
    logic go_scan;
    logic scan_hit;
  } seq_stat_t;

  // port table write bundle
  typedef struct packed {
    logic   bind_we;
    logic   flags_we;
    port_t  waddr;
    chan_t  chan;
    owner_t owner;
    flags_t flags;
  } tbl_wr_t;

endpackage

`default_nettype wire

>>> src/ara_table.sv
// ----------------------------------------------------------------------------
// ara_table: per-port channel, owner and pending-flag storage
// flop arrays with one shared read address chosen by the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ara_table #(
  parameter int NUM_PORTS = ara_pkg::DefNumPorts,
  parameter int PortW     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1
) (
  input  wire logic             clk_i,
  input  wire ara_pkg::tbl_wr_t wr_i,
  input  wire logic [PortW-1:0] rd_addr_i,
  output ara_pkg::chan_t        rd_chan_o,
  output ara_pkg::owner_t       rd_owner_o,
  output ara_pkg::flags_t       rd_flags_o
);
  import ara_pkg::*;

  chan_t  chan_q  [NUM_PORTS];
  owner_t owner_q [NUM_PORTS];
  flags_t flags_q [NUM_PORTS];

  logic [PortW-1:0] waddr;
  assign waddr = wr_i.waddr[PortW-1:0];

  // entries are never read before written, so no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.bind_we) begin
      chan_q[waddr]  <= wr_i.chan;
      owner_q[waddr] <= wr_i.owner;
    end
    if (wr_i.flags_we) begin
      flags_q[waddr] <= wr_i.flags;
    end
  end

  assign rd_chan_o  = chan_q[rd_addr_i];
  assign rd_owner_o = owner_q[rd_addr_i];
  assign rd_flags_o = flags_q[rd_addr_i];

endmodule

`default_nettype wire

>>> src/ara_seq.sv
// ----------------------------------------------------------------------------
// ara_seq: sequencer of the arbiter
// steps one beat through execute, pending scan and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ara_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ara_pkg::seq_stat_t stat_i,
  output ara_pkg::seq_ctrl_t      ctrl_o,
  output ara_pkg::state_e         state_o
);
  import ara_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = stat_i.go_scan ? ST_SCAN : ST_OUT;
      end
      ST_SCAN: begin
        if (stat_i.scan_hit) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE: ctrl_o.ready     = 1'b1;
      ST_EXEC: ctrl_o.exec_en   = 1'b1;
      ST_SCAN: ctrl_o.scan_en   = 1'b1;
      ST_OUT:  ctrl_o.out_valid = 1'b1;
      default: ctrl_o = '0;
    endcase
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

>>> src/adc_request_arbiter_unit.sv
// ----------------------------------------------------------------------------
// adc_request_arbiter_unit: shares one converter among logical ports
// bind, unbind, sample request and conversion-done handling with a
// lowest-port-first pending scan and bandgap reference capture
// ----------------------------------------------------------------------------
// One beat is taken at a time. An accepted beat passes through the execute
// step and then waits in the output register until the result beat is taken;
// the next beat is accepted once the block is back in idle. A conversion-done
// with requests pending also walks the pending mask one port per cycle through
// the single table read port, starting at port 0 and stopping at the lowest
// pending port, before its result is shown. s_axis_tready is high only while
// the block holds no beat. There is no clearing pass after reset; port tables
// are only read once bound or pending. bandgap_channel is written at paddr 0
// over the APB port and should be changed only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module adc_request_arbiter_unit #(
  parameter int NUM_PORTS = ara_pkg::DefNumPorts
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // port_index[3:0], channel[7:4], caller_id[15:8], request_flags[23:16],
  // sample[35:24], zero pad[39:36]
  input  wire logic [ara_pkg::InDataW-1:0]   s_axis_tdata,
  // command[1:0]
  input  wire logic [ara_pkg::InUserW-1:0]   s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // deliver_valid[0], deliver_port[4:1], deliver_sample[16:5],
  // deliver_flags[24:17], start_valid[25], start_channel[29:26],
  // reference_value[45:30], zero pad[47:46]
  output logic [ara_pkg::OutDataW-1:0]       m_axis_tdata,
  // status[1:0]
  output logic [ara_pkg::OutUserW-1:0]       m_axis_tuser,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ara_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [ara_pkg::CfgDataW-1:0]  pwdata,
  output logic [ara_pkg::CfgDataW-1:0]       prdata,
  output logic                               pready
);
  import ara_pkg::*;

  localparam int PortW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam logic [PortBits:0] NumPortsW = (PortBits+1)'(NUM_PORTS);
  localparam chan_t MaxChan = ChanBits'(MaxChannel);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  chan_t bandgap_q;
  logic  cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bandgap_q <= ResetBandgap;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      bandgap_q <= pwdata[ChanBits-1:0];
    end
  end

  assign prdata = cfg_sel ? CfgDataW'(bandgap_q) : '0;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  seq_ctrl_t ctrl;
  seq_stat_t stat;
  state_e    state;

  ara_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .state_o (state)
  );

  assign s_axis_tready = ctrl.ready;
  assign m_axis_tvalid = ctrl.out_valid;

  // --------------------------------------------------------------------------
  // captured command beat
  // --------------------------------------------------------------------------
  cmd_e                cmd_q;
  port_t               port_q;
  chan_t               chan_q;
  owner_t              caller_q;
  flags_t              flags_q;
  logic [SampleW-1:0]  sample_q;
  logic                in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= cmd_e'(s_axis_tuser);
      port_q   <= s_axis_tdata[3:0];
      chan_q   <= s_axis_tdata[7:4];
      caller_q <= s_axis_tdata[15:8];
      flags_q  <= s_axis_tdata[23:16];
      sample_q <= s_axis_tdata[35:24];
    end
  end

  // --------------------------------------------------------------------------
  // arbiter state
  // --------------------------------------------------------------------------
  logic                 busy_q, busy_d;
  logic [NUM_PORTS-1:0] bound_q, bound_d;
  logic [NUM_PORTS-1:0] pending_q, pending_d;
  logic [PortW-1:0]     active_q, active_d;
  flags_t               act_flags_q, act_flags_d;
  logic [RefBits-1:0]   ref_q, ref_d;
  logic [PortW-1:0]     scan_q, scan_d;

  // result register
  status_e             status_q, status_d;
  logic                dv_q, dv_d;
  port_t               dport_q, dport_d;
  logic [SampleW-1:0]  dsample_q, dsample_d;
  flags_t              dflags_q, dflags_d;
  logic                sv_q, sv_d;
  chan_t               schan_q, schan_d;

  // --------------------------------------------------------------------------
  // port table, one read address a cycle
  // --------------------------------------------------------------------------
  tbl_wr_t          tbl_wr;
  logic [PortW-1:0] rd_addr;
  logic [PortW-1:0] port_idx;
  chan_t            rd_chan;
  owner_t           rd_owner;
  flags_t           rd_flags;

  assign port_idx = port_q[PortW-1:0];

  // scan walks the pending ports, done reads the active port, others their own port
  always_comb begin
    if (state == ST_SCAN) begin
      rd_addr = scan_q;
    end else if (cmd_q == CMD_DONE) begin
      rd_addr = active_q;
    end else begin
      rd_addr = port_idx;
    end
  end

  ara_table #(
    .NUM_PORTS (NUM_PORTS),
    .PortW     (PortW)
  ) u_table (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_addr_i  (rd_addr),
    .rd_chan_o  (rd_chan),
    .rd_owner_o (rd_owner),
    .rd_flags_o (rd_flags)
  );

  // --------------------------------------------------------------------------
  // execute and scan datapath
  // --------------------------------------------------------------------------
  logic                 port_ok;
  logic                 bound_hit;
  logic                 owner_match;
  logic [NUM_PORTS-1:0] port_bit;
  logic [NUM_PORTS-1:0] scan_bit;
  logic                 scan_hit;

  assign port_ok     = ({1'b0, port_q} < NumPortsW);
  assign bound_hit   = port_ok && bound_q[port_idx];
  assign owner_match = (rd_owner == caller_q);
  assign scan_hit    = pending_q[scan_q];

  always_comb begin
    port_bit = '0;
    if (port_ok) port_bit[port_idx] = 1'b1;
    scan_bit = '0;
    scan_bit[scan_q] = 1'b1;
  end

  assign stat.in_fire  = in_fire;
  assign stat.out_fire = m_axis_tvalid && m_axis_tready;
  assign stat.go_scan  = (cmd_q == CMD_DONE) && busy_q && (pending_q != '0);
  assign stat.scan_hit = scan_hit;

  always_comb begin
    busy_d      = busy_q;
    bound_d     = bound_q;
    pending_d   = pending_q;
    active_d    = active_q;
    act_flags_d = act_flags_q;
    ref_d       = ref_q;
    scan_d      = scan_q;
    status_d    = status_q;
    dv_d        = dv_q;
    dport_d     = dport_q;
    dsample_d   = dsample_q;
    dflags_d    = dflags_q;
    sv_d        = sv_q;
    schan_d     = schan_q;
    tbl_wr      = '0;
    tbl_wr.waddr = port_q;
    tbl_wr.chan  = chan_q;
    tbl_wr.owner = caller_q;
    tbl_wr.flags = flags_q;

    if (ctrl.exec_en) begin
      status_d  = STS_OK;
      dv_d      = 1'b0;
      dport_d   = '0;
      dsample_d = '0;
      dflags_d  = '0;
      sv_d      = 1'b0;
      schan_d   = '0;
      scan_d    = '0;
      case (cmd_q)
        CMD_BIND: begin
          if (!port_ok || (chan_q > MaxChan)) begin
            status_d = STS_INVALID;
          end else if (busy_q || (bound_hit && !owner_match)) begin
            status_d = STS_BUSY;
          end else begin
            tbl_wr.bind_we = 1'b1;
            bound_d        = bound_q | port_bit;
          end
        end
        CMD_UNBIND: begin
          if (!bound_hit || !owner_match) begin
            status_d = STS_INVALID;
          end else begin
            // dropping the pending bit keeps an unmapped port from starting
            bound_d   = bound_q & ~port_bit;
            pending_d = pending_q & ~port_bit;
          end
        end
        CMD_REQUEST: begin
          if (!bound_hit) begin
            status_d = STS_INVALID;
          end else if (busy_q) begin
            pending_d       = pending_q | port_bit;
            tbl_wr.flags_we = 1'b1;
          end else begin
            busy_d      = 1'b1;
            active_d    = port_idx;
            act_flags_d = flags_q;
            sv_d        = 1'b1;
            schan_d     = rd_chan;
          end
        end
        CMD_DONE: begin
          if (!busy_q) begin
            // stray completion
            status_d = STS_IGNORED;
          end else begin
            dv_d      = 1'b1;
            dport_d   = port_t'(active_q);
            dsample_d = sample_q & SampleMask;
            dflags_d  = act_flags_q;
            // no capture when the active port was unbound mid-conversion
            if (bound_q[active_q] && (rd_chan == bandgap_q)) begin
              ref_d = RefBits'(sample_q & SampleMask);
            end
            busy_d = 1'b0;
          end
        end
        default: status_d = STS_OK;
      endcase
    end

    // lowest pending port first, one port per cycle
    if (ctrl.scan_en) begin
      if (scan_hit) begin
        pending_d   = pending_q & ~scan_bit;
        busy_d      = 1'b1;
        active_d    = scan_q;
        act_flags_d = rd_flags;
        sv_d        = 1'b1;
        schan_d     = rd_chan;
      end else begin
        scan_d = scan_q + PortW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      bound_q     <= '0;
      pending_q   <= '0;
      active_q    <= '0;
      act_flags_q <= '0;
      ref_q       <= ResetReference;
      scan_q      <= '0;
    end else begin
      busy_q      <= busy_d;
      bound_q     <= bound_d;
      pending_q   <= pending_d;
      active_q    <= active_d;
      act_flags_q <= act_flags_d;
      ref_q       <= ref_d;
      scan_q      <= scan_d;
    end
  end

  // result payload, held until the beat is taken
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    dv_q      <= dv_d;
    dport_q   <= dport_d;
    dsample_q <= dsample_d;
    dflags_q  <= dflags_d;
    sv_q      <= sv_d;
    schan_q   <= schan_d;
  end

  // --------------------------------------------------------------------------
  // result beat packing
  // --------------------------------------------------------------------------
  assign m_axis_tuser = status_q;
  assign m_axis_tdata = {2'b00, ref_q, schan_q, sv_q, dflags_q, dsample_q, dport_q, dv_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // only bound ports may wait for a conversion
  a_pending_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~bound_q) == '0)
    else $error("pending port is not bound");

  // one beat at a time: never ready while a result is shown
  a_one_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result held");

  // a reported start leaves the converter busy
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && sv_q) |-> busy_q)
    else $error("start reported while idle");

  // a delivery always carries ok status
  a_deliver_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && dv_q) |-> (status_q == STS_OK))
    else $error("delivery with non-ok status");

endmodule

`default_nettype wire

>>> bench/ara_beat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ara_beat_checker: result checker for the converter request arbiter
// follows command beats, bandgap writes and result beats, predicts every
// result beat from its own copy of the port tables and compares in order
// ----------------------------------------------------------------------------

module ara_beat_checker #(
  parameter logic [ara_pkg::CfgAddrW-1:0] BandgapAddr = '0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [ara_pkg::InDataW-1:0]   s_tdata,
  input  logic [ara_pkg::InUserW-1:0]   s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [ara_pkg::OutDataW-1:0]  m_tdata,
  input  logic [ara_pkg::OutUserW-1:0]  m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [ara_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ara_pkg::CfgDataW-1:0]  pwdata,
  output int                            fail_count,
  output int                            outstanding,
  output int                            results_seen,
  output int                            samples_delivered,
  output int                            reference_updates
);
  import ara_pkg::*;

  localparam int NumPorts  = DefNumPorts;
  localparam int MaxShown  = 10;

  typedef struct packed {
    status_e               status;
    logic                  dv;
    port_t                 dport;
    logic [SampleW-1:0]    dsample;
    flags_t                dflags;
    logic                  sv;
    chan_t                 schan;
    logic [RefBits-1:0]    refv;
    logic [1:0]            pad;
  } result_t;

  // predictor state
  logic                  busy;
  chan_t                 port_chan     [NumPorts];
  owner_t                port_owner    [NumPorts];
  flags_t                waiting_flags [NumPorts];
  logic [NumPorts-1:0]   bound;
  logic [NumPorts-1:0]   waiting;
  port_t                 active_port;
  flags_t                active_flags;
  logic [RefBits-1:0]    reference;
  chan_t                 bandgap;

  result_t expected_results[$];
  int      shown = 0;

  initial begin
    fail_count        = 0;
    outstanding       = 0;
    results_seen      = 0;
    samples_delivered = 0;
    reference_updates = 0;
  end

  // make port p the converting one, returns its channel
  function automatic chan_t launch(port_t p, flags_t fl);
    busy         = 1'b1;
    active_port  = p;
    active_flags = fl;
    return port_chan[p];
  endfunction

  function automatic result_t arbitrate(cmd_e c, port_t p, chan_t ch, owner_t who,
                                        flags_t fl, logic [SampleW-1:0] smp);
    result_t             r;
    logic                in_range;
    logic [NumPorts-1:0] sel;
    r        = '0;
    r.status = STS_OK;
    in_range = int'(p) < NumPorts;
    sel      = '0;
    if (in_range) sel[p] = 1'b1;
    case (c)
      CMD_BIND: begin
        if (!in_range || int'(ch) > MaxChannel) begin
          r.status = STS_INVALID;
        end else if (busy || ((bound & sel) != '0 && port_owner[p] != who)) begin
          r.status = STS_BUSY;
        end else begin
          port_chan[p]  = ch;
          port_owner[p] = who;
          bound         = bound | sel;
        end
      end
      CMD_UNBIND: begin
        if (!in_range || (bound & sel) == '0 || port_owner[p] != who) begin
          r.status = STS_INVALID;
        end else begin
          bound   = bound & ~sel;
          waiting = waiting & ~sel;
        end
      end
      CMD_REQUEST: begin
        if (!in_range || (bound & sel) == '0) begin
          r.status = STS_INVALID;
        end else if (busy) begin
          waiting          = waiting | sel;
          waiting_flags[p] = fl;
        end else begin
          r.sv    = 1'b1;
          r.schan = launch(p, fl);
        end
      end
      default: begin
        if (!busy) begin
          r.status = STS_IGNORED;
        end else begin
          r.dv      = 1'b1;
          r.dport   = active_port;
          r.dsample = smp & SampleMask;
          r.dflags  = active_flags;
          // capture only while the converting port is still mapped to the bandgap
          if (int'(active_port) < NumPorts && bound[active_port] &&
              port_chan[active_port] == bandgap) begin
            reference = RefBits'(smp & SampleMask);
            reference_updates++;
          end
          busy = 1'b0;
          for (int i = 0; i < NumPorts; i++) begin
            if (waiting[i]) begin
              waiting[i] = 1'b0;
              r.sv       = 1'b1;
              r.schan    = launch(port_t'(i), waiting_flags[i]);
              break;
            end
          end
        end
      end
    endcase
    r.refv = reference;
    return r;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("st=%0d dv=%0d port=%0d smp=%03h flg=%02h sv=%0d ch=%0d ref=%04h pad=%0d",
                     r.status, r.dv, r.dport, r.dsample, r.dflags, r.sv, r.schan,
                     r.refv, r.pad);
  endfunction

  function automatic void compare_result(result_t got);
    result_t want;
    string   bad;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (shown < MaxShown) begin
        shown++;
        $display("unexpected result beat, nothing outstanding: %s", describe(got));
      end
      return;
    end
    want = expected_results.pop_front();
    bad  = "";
    if (got.status  !== want.status)  bad = {bad, " status"};
    if (got.dv      !== want.dv)      bad = {bad, " deliver_valid"};
    if (got.dport   !== want.dport)   bad = {bad, " deliver_port"};
    if (got.dsample !== want.dsample) bad = {bad, " deliver_sample"};
    if (got.dflags  !== want.dflags)  bad = {bad, " deliver_flags"};
    if (got.sv      !== want.sv)      bad = {bad, " start_valid"};
    if (got.schan   !== want.schan)   bad = {bad, " start_channel"};
    if (got.refv    !== want.refv)    bad = {bad, " reference_value"};
    if (got.pad     !== want.pad)     bad = {bad, " pad"};
    if (bad != "") begin
      fail_count++;
      if (shown < MaxShown) begin
        shown++;
        $display("result %0d mismatch in%s", results_seen, bad);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy         = 1'b0;
      bound        = '0;
      waiting      = '0;
      active_port  = '0;
      active_flags = '0;
      reference    = ResetReference;
      bandgap      = ResetBandgap;
      for (int i = 0; i < NumPorts; i++) begin
        port_chan[i]     = '0;
        port_owner[i]    = '0;
        waiting_flags[i] = '0;
      end
      expected_results.delete();
    end else begin
      // a result beat always belongs to an older command beat
      if (m_tvalid && m_tready) begin
        compare_result('{status:  status_e'(m_tuser),
                         dv:      m_tdata[0],
                         dport:   m_tdata[4:1],
                         dsample: m_tdata[16:5],
                         dflags:  m_tdata[24:17],
                         sv:      m_tdata[25],
                         schan:   m_tdata[29:26],
                         refv:    m_tdata[45:30],
                         pad:     m_tdata[47:46]});
        results_seen++;
        if (m_tdata[0]) samples_delivered++;
      end
      if (psel && penable && pwrite && pready && paddr == BandgapAddr) begin
        bandgap = chan_t'(pwdata);
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(arbitrate(cmd_e'(s_tuser), s_tdata[3:0], s_tdata[7:4],
                                             s_tdata[15:8], s_tdata[23:16],
                                             s_tdata[35:24]));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the converter request arbiter
// a directed pass over the bind, unbind, request and completion corner
// cases, then random well-formed bind/request/complete bursts mixed with
// noise beats under three idling patterns and several bandgap settings
// ----------------------------------------------------------------------------

module tb;
  import ara_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 7;
  // settling margin after the last result is back
  localparam int DrainCycles = 20;
  // a long receiver hold-off is the longest legal stretch without a beat
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 3000;
  localparam int PhaseBeats  = 300;
  localparam int NumPorts    = DefNumPorts;
  localparam logic [CfgAddrW-1:0] BandgapAddr = '0;

  typedef logic [SampleW-1:0] sample_t;

  logic                 clk_i;
  logic                 rst_ni;
  // command stream
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // port_index[3:0], channel[7:4], caller_id[15:8], request_flags[23:16],
  // sample[35:24], zero pad[39:36]
  logic [InDataW-1:0]   s_axis_tdata;
  // command[1:0]
  logic [InUserW-1:0]   s_axis_tuser;
  // result stream
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // deliver_valid[0], deliver_port[4:1], deliver_sample[16:5],
  // deliver_flags[24:17], start_valid[25], start_channel[29:26],
  // reference_value[45:30], zero pad[47:46]
  logic [OutDataW-1:0]  m_axis_tdata;
  // status[1:0]
  logic [OutUserW-1:0]  m_axis_tuser;
  // configuration
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CfgAddrW-1:0]  paddr;
  logic [CfgDataW-1:0]  pwdata;
  logic [CfgDataW-1:0]  prdata;
  logic                 pready;

  // idling knobs, percent of cycles
  int    tx_idle_pct = 14;
  int    rx_idle_pct = 52;
  bit    hold_go     = 1'b0;
  int    beats_sent  = 0;
  int    quiet_cycles = 0;
  chan_t bandgap_now = ResetBandgap;
  chan_t mid_bandgap;

  int fail_count;
  int outstanding;
  int results_seen;
  int samples_delivered;
  int reference_updates;

  adc_request_arbiter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ara_beat_checker #(
    .BandgapAddr (BandgapAddr)
  ) u_beat_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_tvalid          (s_axis_tvalid),
    .s_tready          (s_axis_tready),
    .s_tdata           (s_axis_tdata),
    .s_tuser           (s_axis_tuser),
    .m_tvalid          (m_axis_tvalid),
    .m_tready          (m_axis_tready),
    .m_tdata           (m_axis_tdata),
    .m_tuser           (m_axis_tuser),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .fail_count        (fail_count),
    .outstanding       (outstanding),
    .results_seen      (results_seen),
    .samples_delivered (samples_delivered),
    .reference_updates (reference_updates)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  // watchdog: cycles with no beat on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("watchdog: no beat for %0d cycles, %0d results outstanding",
             StallLimit, outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

  // result receiver: random back-pressure, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // canonical owner of a port, so well-formed unbinds find their owner
  function automatic owner_t owner_of(port_t p);
    return {p, ~p};
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(cmd_e c, port_t p, chan_t ch, owner_t who, flags_t fl,
                           sample_t smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, smp, fl, who, ch, p};
    s_axis_tuser  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // stop offering and wait until every result is back and the block is idle
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // bandgap channel often enough that captures happen
  function automatic chan_t pick_chan();
    return ($urandom_range(99) < 40) ? bandgap_now : chan_t'($urandom_range(15));
  endfunction

  // drain, bind a few ports, request, maybe unbind, then complete
  task automatic well_formed_burst();
    port_t p;
    repeat ($urandom_range(3, 1)) begin
      send_beat(CMD_DONE, port_t'($urandom_range(15)), chan_t'($urandom_range(15)),
                owner_t'($urandom_range(255)), flags_t'($urandom_range(255)),
                sample_t'($urandom_range(4095)));
    end
    repeat ($urandom_range(3)) begin
      p = port_t'($urandom_range(NumPorts - 1));
      send_beat(CMD_BIND, p, pick_chan(),
                ($urandom_range(9) == 0) ? owner_t'($urandom_range(255)) : owner_of(p),
                flags_t'($urandom_range(255)), sample_t'($urandom_range(4095)));
    end
    repeat ($urandom_range(4, 1)) begin
      p = port_t'($urandom_range(NumPorts - 1));
      send_beat(CMD_REQUEST, p, chan_t'($urandom_range(15)), owner_t'($urandom_range(255)),
                flags_t'($urandom_range(255)), sample_t'($urandom_range(4095)));
    end
    if ($urandom_range(4) == 0) begin
      p = port_t'($urandom_range(NumPorts - 1));
      send_beat(CMD_UNBIND, p, chan_t'($urandom_range(15)),
                ($urandom_range(3) == 0) ? owner_t'($urandom_range(255)) : owner_of(p),
                flags_t'($urandom_range(255)), sample_t'($urandom_range(4095)));
    end
    repeat ($urandom_range(5, 1)) begin
      send_beat(CMD_DONE, port_t'($urandom_range(15)), chan_t'($urandom_range(15)),
                owner_t'($urandom_range(255)), flags_t'($urandom_range(255)),
                sample_t'($urandom_range(4095)));
    end
  endtask

  // one random phase: new bandgap setting and idling pattern, with one long
  // receiver hold-off and one full drain somewhere in the middle
  task automatic run_phase(chan_t bg, int tx_pct, int rx_pct);
    int first;
    bit held;
    bit paused;
    wait_quiet();
    apb_write(BandgapAddr, CfgDataW'(bg));
    bandgap_now = bg;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first  = beats_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (beats_sent - first < PhaseBeats) begin
      if (!held && beats_sent - first >= PhaseBeats / 3) begin
        held    = 1'b1;
        hold_go = 1'b1;
      end
      if (!paused && beats_sent - first >= 2 * PhaseBeats / 3) begin
        paused = 1'b1;
        wait_quiet();
      end
      if ($urandom_range(99) < 15) begin
        // noise: any command, any port, any owner
        send_beat(cmd_e'($urandom_range(3)), port_t'($urandom_range(15)),
                  chan_t'($urandom_range(15)), owner_t'($urandom_range(255)),
                  flags_t'($urandom_range(255)), sample_t'($urandom_range(4095)));
      end else begin
        well_formed_burst();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mid_bandgap   = chan_t'($urandom_range(14, 1));

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed pass, bandgap on channel 10
    apb_write(BandgapAddr, CfgDataW'(4'd10));
    bandgap_now = 4'd10;
    @(negedge clk_i);

    // completion with nothing converting is ignored
    send_beat(CMD_DONE, 4'd0, 4'd0, 8'h00, 8'h00, 12'h000);
    // ports past the table are rejected
    send_beat(CMD_BIND, 4'd12, 4'd3, 8'h12, 8'h00, 12'h000);
    send_beat(CMD_BIND, 4'd15, 4'd15, 8'hff, 8'hff, 12'hfff);
    // unbind and request on a port nobody bound
    send_beat(CMD_UNBIND, 4'd3, 4'd0, 8'h33, 8'h00, 12'h000);
    send_beat(CMD_REQUEST, 4'd3, 4'd0, 8'h33, 8'h11, 12'h000);
    // first and last port bound, port 0 to the bandgap channel
    send_beat(CMD_BIND, 4'd0, 4'd10, 8'h00, 8'h00, 12'h000);
    send_beat(CMD_BIND, 4'd11, 4'd15, 8'hff, 8'h00, 12'h000);
    // another client cannot take port 0, its owner can remap it
    send_beat(CMD_BIND, 4'd0, 4'd5, 8'h55, 8'h00, 12'h000);
    send_beat(CMD_BIND, 4'd0, 4'd10, 8'h00, 8'h00, 12'h000);
    // start a conversion, then bind while busy is refused
    send_beat(CMD_REQUEST, 4'd0, 4'd0, 8'h00, 8'hff, 12'h000);
    send_beat(CMD_BIND, 4'd5, 4'd1, 8'h05, 8'h00, 12'h000);
    // queue port 11 twice, the second flags win
    send_beat(CMD_REQUEST, 4'd11, 4'd0, 8'h00, 8'h00, 12'h000);
    send_beat(CMD_REQUEST, 4'd11, 4'd0, 8'h00, 8'ha5, 12'h000);
    send_beat(CMD_REQUEST, 4'd15, 4'd0, 8'h00, 8'h00, 12'h000);
    send_beat(CMD_UNBIND, 4'd15, 4'd0, 8'hff, 8'h00, 12'h000);
    // full-scale sample captured as reference, port 11 starts next
    send_beat(CMD_DONE, 4'd0, 4'd0, 8'h00, 8'h00, 12'hfff);
    // wrong owner, then the owner unbinds the converting port
    send_beat(CMD_UNBIND, 4'd11, 4'd0, 8'h12, 8'h00, 12'h000);
    send_beat(CMD_UNBIND, 4'd11, 4'd0, 8'hff, 8'h00, 12'h000);
    // unbound active port still gets its zero sample
    send_beat(CMD_DONE, 4'd0, 4'd0, 8'h00, 8'h00, 12'h000);
    send_beat(CMD_DONE, 4'd0, 4'd0, 8'h00, 8'h00, 12'h000);
    // port requests itself while converting, then unbind drops the pending bit
    send_beat(CMD_REQUEST, 4'd0, 4'd0, 8'h00, 8'h3c, 12'h000);
    send_beat(CMD_REQUEST, 4'd0, 4'd0, 8'h00, 8'hc3, 12'h000);
    send_beat(CMD_UNBIND, 4'd0, 4'd0, 8'h00, 8'h00, 12'h000);
    send_beat(CMD_DONE, 4'd0, 4'd0, 8'h00, 8'h00, 12'h123);
    // last port on the bandgap channel, capture from it
    send_beat(CMD_BIND, 4'd11, 4'd10, 8'hff, 8'h00, 12'h000);
    send_beat(CMD_REQUEST, 4'd11, 4'd0, 8'hff, 8'h81, 12'h000);
    send_beat(CMD_DONE, 4'd0, 4'd0, 8'h00, 8'h00, 12'h800);

    // random phases: sender light / receiver heavy, swapped, then no idling
    run_phase(4'd15, 14, 52);
    run_phase(4'd0, 52, 14);
    run_phase(mid_bandgap, 0, 0);

    wait_quiet();
    @(posedge clk_i);

    $display("covered %0d command beats over bandgap channels 10, 15, 0 and %0d",
             beats_sent, mid_bandgap);
    $display("%0d result beats checked, %0d samples delivered, %0d reference captures",
             results_seen, samples_delivered, reference_updates);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/ara_pkg.sv
src/ara_table.sv
src/ara_seq.sv
src/adc_request_arbiter_unit.sv
bench/ara_beat_checker.sv
bench/tb.sv
